// ===== rtl/qcpm_pkg.sv =====
// ----------------------------------------------------------------------------
// qcpm_pkg
// Types, widths and constants shared by the cascaded pid mixer modules.
// ----------------------------------------------------------------------------
package qcpm_pkg;

   localparam int IN_W         = 16;
   localparam int MOTOR_W      = 16;
   localparam int OUTER_GAIN_W = 60;
   localparam int OUTER_K_W    = 20;
   localparam int INNER_GAIN_W = 32;
   localparam int INNER_K_W    = 16;
   localparam int LIMIT_W      = 15;
   localparam int THRESH_W     = 16;
   localparam int NUM_AXES     = 3;
   localparam int NUM_MOTORS   = 4;
   localparam int AXIS_W       = 2;
   localparam int MOTOR_IDX_W  = 2;

   // outer sum magnitude stays below 2^40 at the default angle format
   localparam int SUM_W  = 42;
   localparam int MUL_A_W = OUTER_K_W + 1;
   localparam int MUL_W  = MUL_A_W + SUM_W;
   localparam int ACC_W  = 64;

   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 64;

   localparam int THROTTLE_OFFSET = 500;

   localparam logic [OUTER_GAIN_W-1:0] OUTER_PITCH_RST = 60'd286720;
   localparam logic [OUTER_GAIN_W-1:0] OUTER_ROLL_RST  = 60'd256000;
   localparam logic [OUTER_GAIN_W-1:0] OUTER_YAW_RST   = 60'd1536;
   localparam logic [INNER_GAIN_W-1:0] INNER_PITCH_RST = 32'd8587837;
   localparam logic [INNER_GAIN_W-1:0] INNER_ROLL_RST  = 32'd8587837;
   localparam logic [INNER_GAIN_W-1:0] INNER_YAW_RST   = 32'd51514311;
   localparam logic [LIMIT_W-1:0]      LIMIT_RST       = 15'd19200;
   localparam logic [THRESH_W-1:0]     THRESH_RST      = 16'd1000;

   localparam logic [AXIS_W-1:0] AXIS_ROLL  = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_PITCH = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_YAW   = 2'd2;

   localparam logic [MOTOR_IDX_W-1:0] MOTOR_FA = 2'd0;
   localparam logic [MOTOR_IDX_W-1:0] MOTOR_FB = 2'd1;
   localparam logic [MOTOR_IDX_W-1:0] MOTOR_RA = 2'd2;
   localparam logic [MOTOR_IDX_W-1:0] MOTOR_RB = 2'd3;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_OUTER_PITCH = 3'd0,
      CSR_OUTER_ROLL  = 3'd1,
      CSR_OUTER_YAW   = 3'd2,
      CSR_INNER_PITCH = 3'd3,
      CSR_INNER_ROLL  = 3'd4,
      CSR_INNER_YAW   = 3'd5,
      CSR_INT_LIMIT   = 3'd6,
      CSR_THRESHOLD   = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_KP,
      OP_KI,
      OP_KD,
      OP_CD,
      OP_CP
   } mul_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_KP,
      ST_KI,
      ST_KD,
      ST_CD,
      ST_CP,
      ST_FLUSH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [NUM_AXES-1:0][OUTER_GAIN_W-1:0] outer_gains;
      logic [NUM_AXES-1:0][INNER_GAIN_W-1:0] inner_gains;
      logic [LIMIT_W-1:0]                    integral_limit;
      logic [THRESH_W-1:0]                   throttle_threshold;
   } csr_regs_type;

   typedef struct packed {
      logic              load;
      logic              prep_en;
      logic [AXIS_W-1:0] prep_axis;
      mul_op_type        mul_op;
      logic [AXIS_W-1:0] mul_axis;
      logic              out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   // x-mode mixer: 1 where the axis correction is subtracted from the motor
   function automatic logic mix_neg(input logic [AXIS_W-1:0] axis,
                                    input logic [MOTOR_IDX_W-1:0] motor);
      logic neg;
      case (axis)
         AXIS_ROLL:  neg = (motor == MOTOR_FB) || (motor == MOTOR_RA);
         AXIS_PITCH: neg = (motor == MOTOR_RA) || (motor == MOTOR_RB);
         AXIS_YAW:   neg = (motor == MOTOR_FB) || (motor == MOTOR_RB);
         default:    neg = 1'b0;
      endcase
      return neg;
   endfunction

endpackage

// ===== rtl/qcpm_csr.sv =====
// ----------------------------------------------------------------------------
// qcpm_csr
// Gain, integral limit and throttle threshold registers with write port.
// ----------------------------------------------------------------------------
module qcpm_csr import qcpm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output csr_regs_type          regs
);

   logic [OUTER_GAIN_W-1:0] outer_pitch_ff, outer_roll_ff, outer_yaw_ff;
   logic [INNER_GAIN_W-1:0] inner_pitch_ff, inner_roll_ff, inner_yaw_ff;
   logic [LIMIT_W-1:0]      limit_ff;
   logic [THRESH_W-1:0]     thresh_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         outer_pitch_ff <= OUTER_PITCH_RST;
         outer_roll_ff  <= OUTER_ROLL_RST;
         outer_yaw_ff   <= OUTER_YAW_RST;
         inner_pitch_ff <= INNER_PITCH_RST;
         inner_roll_ff  <= INNER_ROLL_RST;
         inner_yaw_ff   <= INNER_YAW_RST;
         limit_ff       <= LIMIT_RST;
         thresh_ff      <= THRESH_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_addr))
            CSR_OUTER_PITCH: outer_pitch_ff <= csr_wdata[OUTER_GAIN_W-1:0];
            CSR_OUTER_ROLL:  outer_roll_ff  <= csr_wdata[OUTER_GAIN_W-1:0];
            CSR_OUTER_YAW:   outer_yaw_ff   <= csr_wdata[OUTER_GAIN_W-1:0];
            CSR_INNER_PITCH: inner_pitch_ff <= csr_wdata[INNER_GAIN_W-1:0];
            CSR_INNER_ROLL:  inner_roll_ff  <= csr_wdata[INNER_GAIN_W-1:0];
            CSR_INNER_YAW:   inner_yaw_ff   <= csr_wdata[INNER_GAIN_W-1:0];
            CSR_INT_LIMIT:   limit_ff       <= csr_wdata[LIMIT_W-1:0];
            CSR_THRESHOLD:   thresh_ff      <= csr_wdata[THRESH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // registers are listed pitch first, the datapath indexes roll first
   always_comb begin
      regs.outer_gains[AXIS_ROLL]  = outer_roll_ff;
      regs.outer_gains[AXIS_PITCH] = outer_pitch_ff;
      regs.outer_gains[AXIS_YAW]   = outer_yaw_ff;
      regs.inner_gains[AXIS_ROLL]  = inner_roll_ff;
      regs.inner_gains[AXIS_PITCH] = inner_pitch_ff;
      regs.inner_gains[AXIS_YAW]   = inner_yaw_ff;
      regs.integral_limit          = limit_ff;
      regs.throttle_threshold      = thresh_ff;
   end

endmodule

// ===== rtl/qcpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// qcpm_ctrl
// Sequencer: walks the three axes through the shared multiplier.
// ----------------------------------------------------------------------------
module qcpm_ctrl import qcpm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type         state_ff, state_in;
   logic [AXIS_W-1:0] axis_ff, axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= AXIS_ROLL;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      axis_in       = axis_ff;
      req_tready    = 1'b0;
      cmd.load      = 1'b0;
      cmd.prep_en   = 1'b0;
      cmd.prep_axis = axis_ff;
      cmd.mul_op    = OP_NONE;
      cmd.mul_axis  = axis_ff;
      cmd.out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               axis_in  = AXIS_ROLL;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep_en = 1'b1;
            state_in    = ST_KP;
         end
         ST_KP: begin
            cmd.mul_op = OP_KP;
            state_in   = ST_KI;
         end
         ST_KI: begin
            cmd.mul_op = OP_KI;
            state_in   = ST_KD;
         end
         ST_KD: begin
            cmd.mul_op = OP_KD;
            state_in   = ST_CD;
         end
         ST_CD: begin
            cmd.mul_op = OP_CD;
            state_in   = ST_CP;
         end
         ST_CP: begin
            // the next axis is prepared while this one's last product is issued
            cmd.mul_op = OP_CP;
            if (axis_ff == AXIS_YAW) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.prep_en   = 1'b1;
               cmd.prep_axis = axis_ff + 2'd1;
               axis_in       = axis_ff + 2'd1;
               state_in      = ST_KP;
            end
         end
         ST_FLUSH: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_accept_starts_prep: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_PREP) && (axis_ff == AXIS_ROLL))
      else $error("accepted transaction did not start with roll preparation");

   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      axis_ff <= AXIS_YAW)
      else $error("axis counter out of range");

   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded over an untaken result");

   a_prep_axis_next: assert property (@(posedge clock) disable iff (reset)
      (cmd.prep_en && (state_ff == ST_CP)) |-> (cmd.prep_axis == cmd.mul_axis + 2'd1))
      else $error("overlapped preparation on wrong axis");

endmodule

// ===== rtl/qcpm_dp.sv =====
// ----------------------------------------------------------------------------
// qcpm_dp
// Datapath: axis state, shared multiplier, outer sum and motor accumulators.
// ----------------------------------------------------------------------------
module qcpm_dp import qcpm_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  csr_regs_type          csr,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [0:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int OuterFrac = 10 + ANGLE_FRAC_BITS;
   localparam int TotalFrac = OuterFrac + 16;

   // latched item
   logic signed [IN_W-1:0]  err_in_ff  [NUM_AXES];
   logic signed [IN_W-1:0]  gyro_in_ff [NUM_AXES];
   logic                    run_ff;

   // per axis history
   logic signed [IN_W-1:0]  int_ff        [NUM_AXES];
   logic signed [IN_W-1:0]  last_angle_ff [NUM_AXES];
   logic signed [IN_W-1:0]  last_gyro_ff  [NUM_AXES];

   // operands of the axis being worked on
   logic signed [IN_W-1:0]  err_ff, integ_ff;
   logic signed [IN_W:0]    diff_ff, gdiff_ff;
   logic signed [SUM_W-1:0] shell_ff;

   logic signed [ACC_W-1:0] prod_ff;
   logic                    prod_vld_ff;
   mul_op_type              prod_op_ff;
   logic [AXIS_W-1:0]       prod_axis_ff;

   logic signed [ACC_W-1:0] mot_ff [NUM_MOTORS];

   logic                    rsp_valid_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   // item fields
   logic [IN_W-1:0]         req_throttle;
   logic signed [IN_W:0]    thr_off;
   logic signed [ACC_W-1:0] base_acc;
   logic                    req_run;

   // preparation
   logic signed [IN_W-1:0]  p_err, p_gyro, p_integ;
   logic signed [IN_W:0]    p_integ_raw, p_lim, p_neg_lim, p_diff, p_gdiff;
   logic signed [IN_W+2:0]  p_gyro7;
   logic signed [SUM_W-1:0] p_shell0;

   // multiplier
   logic [OUTER_GAIN_W-1:0] og;
   logic [INNER_GAIN_W-1:0] ig;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [SUM_W-1:0]   mul_b;
   logic signed [MUL_W-1:0]   mul_res;

   // saturation
   logic signed [ACC_W-1:0] mot_q   [NUM_MOTORS];
   logic [MOTOR_W-1:0]      mot_sat [NUM_MOTORS];

   assign req_throttle = req_tdata[7*IN_W-1:6*IN_W];
   assign thr_off      = $signed({1'b0, req_throttle}) - (IN_W+1)'(THROTTLE_OFFSET);
   assign base_acc     = ACC_W'(thr_off) <<< TotalFrac;
   assign req_run      = req_tuser[0] && (req_throttle > csr.throttle_threshold);

   always_comb begin
      p_err       = err_in_ff[cmd.prep_axis];
      p_gyro      = gyro_in_ff[cmd.prep_axis];
      p_lim       = $signed({2'b00, csr.integral_limit});
      p_neg_lim   = -p_lim;
      p_integ_raw = (IN_W+1)'(p_err) + (IN_W+1)'(int_ff[cmd.prep_axis]);
      if (p_integ_raw > p_lim) begin
         p_integ = p_lim[IN_W-1:0];
      end else if (p_integ_raw < p_neg_lim) begin
         p_integ = p_neg_lim[IN_W-1:0];
      end else begin
         p_integ = p_integ_raw[IN_W-1:0];
      end
      p_diff   = (IN_W+1)'(p_err) - (IN_W+1)'(last_angle_ff[cmd.prep_axis]);
      p_gdiff  = (IN_W+1)'(p_gyro) - (IN_W+1)'(last_gyro_ff[cmd.prep_axis]);
      // 3.5 * gyro at the outer format
      p_gyro7  = ((IN_W+3)'(p_gyro) <<< 3) - (IN_W+3)'(p_gyro);
      p_shell0 = SUM_W'(p_gyro7) <<< (OuterFrac - 1);
   end

   always_comb begin
      og    = csr.outer_gains[cmd.mul_axis];
      ig    = csr.inner_gains[cmd.mul_axis];
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         OP_KP: begin
            mul_a = $signed({1'b0, og[OUTER_K_W-1:0]});
            mul_b = SUM_W'(err_ff);
         end
         OP_KI: begin
            mul_a = $signed({1'b0, og[2*OUTER_K_W-1:OUTER_K_W]});
            mul_b = SUM_W'(integ_ff);
         end
         OP_KD: begin
            mul_a = $signed({1'b0, og[3*OUTER_K_W-1:2*OUTER_K_W]});
            mul_b = SUM_W'(diff_ff);
         end
         OP_CD: begin
            mul_a = $signed({{(MUL_A_W-INNER_K_W){1'b0}}, ig[2*INNER_K_W-1:INNER_K_W]});
            mul_b = SUM_W'(gdiff_ff) <<< OuterFrac;
         end
         OP_CP: begin
            mul_a = $signed({{(MUL_A_W-INNER_K_W){1'b0}}, ig[INNER_K_W-1:0]});
            mul_b = shell_ff;
         end
         default: begin
         end
      endcase
   end

   assign mul_res = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         for (int a = 0; a < NUM_AXES; a++) begin
            int_ff[a]        <= '0;
            last_angle_ff[a] <= '0;
            last_gyro_ff[a]  <= '0;
         end
      end else begin
         prod_vld_ff <= (cmd.mul_op != OP_NONE);
         if (cmd.prep_en) begin
            int_ff[cmd.prep_axis]        <= p_integ;
            last_angle_ff[cmd.prep_axis] <= p_err;
            last_gyro_ff[cmd.prep_axis]  <= p_gyro;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= ACC_W'(mul_res);
      prod_op_ff   <= cmd.mul_op;
      prod_axis_ff <= cmd.mul_axis;

      if (cmd.load) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            err_in_ff[a]  <= req_tdata[a*IN_W +: IN_W];
            gyro_in_ff[a] <= req_tdata[(a+NUM_AXES)*IN_W +: IN_W];
         end
         run_ff <= req_run;
      end

      if (cmd.prep_en) begin
         err_ff   <= p_err;
         integ_ff <= p_integ;
         diff_ff  <= p_diff;
         gdiff_ff <= p_gdiff;
         shell_ff <= p_shell0;
      end else if (prod_vld_ff && (prod_op_ff inside {OP_KP, OP_KI, OP_KD})) begin
         shell_ff <= shell_ff + $signed(prod_ff[SUM_W-1:0]);
      end

      // inner products go straight into the motor sums with mixer signs
      for (int m = 0; m < NUM_MOTORS; m++) begin
         if (cmd.load) begin
            mot_ff[m] <= base_acc;
         end else if (prod_vld_ff && (prod_op_ff inside {OP_CD, OP_CP})) begin
            if (mix_neg(prod_axis_ff, MOTOR_IDX_W'(m))) begin
               mot_ff[m] <= mot_ff[m] - prod_ff;
            end else begin
               mot_ff[m] <= mot_ff[m] + prod_ff;
            end
         end
      end
   end

   always_comb begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
         mot_q[m] = mot_ff[m] >>> TotalFrac;
         if (mot_ff[m] <= 0) begin
            mot_sat[m] = '0;
         end else if (|mot_q[m][ACC_W-1:MOTOR_W]) begin
            mot_sat[m] = '1;
         end else begin
            mot_sat[m] = mot_q[m][MOTOR_W-1:0];
         end
      end
      if (run_ff) begin
         rsp_data_in = {mot_sat[3], mot_sat[2], mot_sat[1], mot_sat[0]};
      end else begin
         rsp_data_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

   a_load_no_product: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !prod_vld_ff)
      else $error("product in flight when a new transaction was loaded");

   a_out_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("waiting motor transaction changed before it was taken");

endmodule

// ===== rtl/quad_cascaded_pid_mixer_core.sv =====
// ----------------------------------------------------------------------------
// quad_cascaded_pid_mixer_core
// Cascaded angle/rate pid for three axes with x-mode quad motor mixer.
// ----------------------------------------------------------------------------
// req_* carries one sensor sample per transaction; rsp_* returns the four
// motor drives for it. csr_* writes gains, the integral limit and the throttle
// threshold; writes are meant for times when no transaction is in progress.
// Each axis takes five products (outer p, i, d, inner d, inner p) on one
// shared 21x42 multiplier, so an item passes through a preparation step,
// the products of all three axes, a flush and a result load before
// rsp_tvalid rises; the next item is taken only after the result load,
// so items do not overlap in the datapath.
// The result sits in an output register; a new item is accepted while it
// waits. A stalled receiver only holds the sequencer at its last step.
// Reset (synchronous) restores the register defaults and clears the axis
// integrals and the stored angle and gyro history. The history updates on
// every item, whether or not the motors are armed.
// ----------------------------------------------------------------------------
module quad_cascaded_pid_mixer_core import qcpm_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // roll_error, pitch_error, yaw_error, gyro_x, gyro_y, gyro_z, throttle
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // armed
   input  logic [0:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // motor_front_a, motor_front_b, motor_rear_a, motor_rear_b
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   csr_regs_type regs;
   cmd_type      cmd;
   status_type   status;

   qcpm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .regs      (regs)
   );

   qcpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   qcpm_dp #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr        (regs),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== tb/quad_cascaded_pid_mixer_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_cascaded_pid_mixer_core_test
// Streams sensor samples through the cascaded pid mixer under a range of gain
// settings and idle patterns, and checks each motor drive transaction against
// a software model of the controller that keeps its own integrals and history.
// ----------------------------------------------------------------------------
import qcpm_pkg::*;

class motor_scoreboard;
   localparam int OUTER_FRAC = 10 + 6;
   localparam int TOTAL_FRAC = OUTER_FRAC + 16;

   logic [OUTER_GAIN_W-1:0] outer_gain [NUM_AXES];
   logic [INNER_GAIN_W-1:0] inner_gain [NUM_AXES];
   logic [LIMIT_W-1:0]      integ_limit;
   logic [THRESH_W-1:0]     run_threshold;
   longint                  integ_acc  [NUM_AXES];
   longint                  last_angle [NUM_AXES];
   longint                  last_rate  [NUM_AXES];
   logic [RSP_DATA_W-1:0]   drives_due [$];
   string                   motor_name [NUM_MOTORS];
   int                      mismatches;
   int                      drives_checked;

   function new();
      int a;
      outer_gain[AXIS_ROLL]  = OUTER_ROLL_RST;
      outer_gain[AXIS_PITCH] = OUTER_PITCH_RST;
      outer_gain[AXIS_YAW]   = OUTER_YAW_RST;
      inner_gain[AXIS_ROLL]  = INNER_ROLL_RST;
      inner_gain[AXIS_PITCH] = INNER_PITCH_RST;
      inner_gain[AXIS_YAW]   = INNER_YAW_RST;
      integ_limit   = LIMIT_RST;
      run_threshold = THRESH_RST;
      for (a = 0; a < NUM_AXES; a++) begin
         integ_acc[a]  = 0;
         last_angle[a] = 0;
         last_rate[a]  = 0;
      end
      motor_name = '{"front_a", "front_b", "rear_a", "rear_b"};
      mismatches = 0;
      drives_checked = 0;
   endfunction

   function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_OUTER_PITCH: outer_gain[AXIS_PITCH] = value[OUTER_GAIN_W-1:0];
         CSR_OUTER_ROLL:  outer_gain[AXIS_ROLL]  = value[OUTER_GAIN_W-1:0];
         CSR_OUTER_YAW:   outer_gain[AXIS_YAW]   = value[OUTER_GAIN_W-1:0];
         CSR_INNER_PITCH: inner_gain[AXIS_PITCH] = value[INNER_GAIN_W-1:0];
         CSR_INNER_ROLL:  inner_gain[AXIS_ROLL]  = value[INNER_GAIN_W-1:0];
         CSR_INNER_YAW:   inner_gain[AXIS_YAW]   = value[INNER_GAIN_W-1:0];
         CSR_INT_LIMIT:   integ_limit   = value[LIMIT_W-1:0];
         CSR_THRESHOLD:   run_threshold = value[THRESH_W-1:0];
         default: ;
      endcase
   endfunction

   // inner loop output with 32 fraction bits, updates the axis history
   function longint axis_correction(int a, longint err, longint rate);
      longint lim, integ, delta, outer, mix;
      longint kp, ki, kd, cp, cd;
      lim = longint'(integ_limit);
      kp = longint'(outer_gain[a][19:0]);
      ki = longint'(outer_gain[a][39:20]);
      kd = longint'(outer_gain[a][59:40]);
      cp = longint'(inner_gain[a][15:0]);
      cd = longint'(inner_gain[a][31:16]);
      integ = integ_acc[a] + err;
      if (integ > lim) integ = lim;
      else if (integ < -lim) integ = -lim;
      integ_acc[a] = integ;
      delta = err - last_angle[a];
      last_angle[a] = err;
      outer = kp * err + ki * integ + kd * delta;
      // 3.5 * rate lined up with the outer output fraction
      mix = outer + rate * 7 * (longint'(1) << (OUTER_FRAC - 1));
      axis_correction = cp * mix + cd * (rate - last_rate[a]) * (longint'(1) << OUTER_FRAC);
      last_rate[a] = rate;
   endfunction

   function logic [MOTOR_W-1:0] clip_motor(longint v);
      longint q;
      if (v <= 0) return '0;
      q = v >>> TOTAL_FRAC;
      return (q > 65535) ? 16'hFFFF : q[15:0];
   endfunction

   function void note_sample(logic [REQ_DATA_W-1:0] data, logic armed);
      longint roll, pitch, yaw, base;
      logic [15:0] thr;
      logic [MOTOR_W-1:0] m [NUM_MOTORS];
      roll  = axis_correction(AXIS_ROLL,  $signed(data[15:0]),  $signed(data[63:48]));
      pitch = axis_correction(AXIS_PITCH, $signed(data[31:16]), $signed(data[79:64]));
      yaw   = axis_correction(AXIS_YAW,   $signed(data[47:32]), $signed(data[95:80]));
      thr = data[111:96];
      if (armed && thr > run_threshold) begin
         base = (longint'(thr) - THROTTLE_OFFSET) * (longint'(1) << TOTAL_FRAC);
         m[MOTOR_FA] = clip_motor(base + roll + pitch + yaw);
         m[MOTOR_FB] = clip_motor(base - roll + pitch - yaw);
         m[MOTOR_RA] = clip_motor(base - roll - pitch + yaw);
         m[MOTOR_RB] = clip_motor(base + roll - pitch - yaw);
      end else begin
         m = '{default: '0};
      end
      drives_due.push_back({m[MOTOR_RB], m[MOTOR_RA], m[MOTOR_FB], m[MOTOR_FA]});
   endfunction

   function void check_drives(logic [RSP_DATA_W-1:0] got);
      logic [RSP_DATA_W-1:0] want;
      int k;
      if (drives_due.size() == 0) begin
         mismatches++;
         $display("%0t: motor transaction %h with no sample outstanding", $time, got);
         return;
      end
      want = drives_due.pop_front();
      drives_checked++;
      for (k = 0; k < NUM_MOTORS; k++) begin
         if (want[MOTOR_W*k +: MOTOR_W] !== got[MOTOR_W*k +: MOTOR_W]) begin
            mismatches++;
            $display("%0t: motor %s expected %0d, got %0d", $time, motor_name[k],
                     want[MOTOR_W*k +: MOTOR_W], got[MOTOR_W*k +: MOTOR_W]);
         end
      end
   endfunction
endclass

module quad_cascaded_pid_mixer_core_test;
   import qcpm_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int NUM_REGS    = 8;
   localparam int NUM_PHASES  = 9;

   typedef enum int {
      SET_DEFAULT,
      SET_ZERO,
      SET_MAX,
      SET_NO_RUN,
      SET_MODERATE,
      SET_WILD,
      SET_CLAMP
   } setting_kind_type;

   typedef struct {
      setting_kind_type gains;
      int               send_idle;
      int               recv_stall;
      int               samples;
   } phase_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   motor_scoreboard board;
   phase_type       plan [NUM_PHASES];
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   int              idle_cycles = 0;
   int              samples_sent = 0;
   int              settings_loaded = 0;

   quad_cascaded_pid_mixer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.write_reg(csr_index_type'(csr_addr), csr_wdata);
         if (req_tvalid && req_tready) board.note_sample(req_tdata, req_tuser[0]);
         if (rsp_tvalid && rsp_tready) board.check_drives(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[quad_cascaded_pid_mixer_core] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [REQ_DATA_W-1:0] pack_sample(input int roll, pitch, yaw,
                                                         gx, gy, gz, thr);
      return {16'(thr), 16'(gz), 16'(gy), 16'(gx), 16'(yaw), 16'(pitch), 16'(roll)};
   endfunction

   function automatic int spread(input int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   function automatic int corner_value();
      case ($urandom_range(5))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3: return -1;
         4: return 1;
         default: return 16384;
      endcase
   endfunction

   task automatic send_sample(input logic [REQ_DATA_W-1:0] data, input logic armed);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= armed;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
   endtask

   // hold the sender until every motor transaction has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.drives_due.size() != 0);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_settings(input setting_kind_type kind);
      logic [CSR_DATA_W-1:0] val [NUM_REGS];
      logic [CSR_DATA_W-1:0] mask;
      int i, w;
      for (i = 0; i < NUM_REGS; i++) val[i] = '0;
      case (kind)
         SET_DEFAULT: begin
            val[CSR_OUTER_PITCH] = 64'(OUTER_PITCH_RST);
            val[CSR_OUTER_ROLL]  = 64'(OUTER_ROLL_RST);
            val[CSR_OUTER_YAW]   = 64'(OUTER_YAW_RST);
            val[CSR_INNER_PITCH] = 64'(INNER_PITCH_RST);
            val[CSR_INNER_ROLL]  = 64'(INNER_ROLL_RST);
            val[CSR_INNER_YAW]   = 64'(INNER_YAW_RST);
            val[CSR_INT_LIMIT]   = 64'(LIMIT_RST);
            val[CSR_THRESHOLD]   = 64'(THRESH_RST);
         end
         SET_MAX: begin
            for (i = 0; i < NUM_REGS; i++) val[i] = '1;
            val[CSR_THRESHOLD] = '0;
         end
         SET_MODERATE, SET_NO_RUN: begin
            for (i = CSR_OUTER_PITCH; i <= CSR_OUTER_YAW; i++)
               val[i] = 64'({20'($urandom_range(4095)), 20'($urandom_range(4095)),
                             20'($urandom_range(4095))});
            for (i = CSR_INNER_PITCH; i <= CSR_INNER_YAW; i++)
               val[i] = 64'({16'($urandom_range(8191)), 16'($urandom_range(8191))});
            val[CSR_INT_LIMIT] = 64'($urandom_range(32767));
            val[CSR_THRESHOLD] = (kind == SET_NO_RUN) ? 64'd65535 : 64'($urandom_range(2000));
         end
         SET_WILD: begin
            for (i = 0; i < NUM_REGS; i++) val[i] = {$urandom, $urandom};
         end
         SET_CLAMP: begin
            for (i = CSR_OUTER_PITCH; i <= CSR_OUTER_YAW; i++)
               val[i] = 64'({20'd1024, 20'd1024, 20'd1024});
            for (i = CSR_INNER_PITCH; i <= CSR_INNER_YAW; i++)
               val[i] = 64'({16'h0100, 16'h4000});
            val[CSR_INT_LIMIT] = 64'd100;
            val[CSR_THRESHOLD] = 64'(THRESH_RST);
         end
         default: ;
      endcase
      for (i = 0; i < NUM_REGS; i++) begin
         w = (i <= CSR_OUTER_YAW) ? OUTER_GAIN_W :
             (i <= CSR_INNER_YAW) ? INNER_GAIN_W :
             (i == CSR_INT_LIMIT) ? LIMIT_W : THRESH_W;
         mask = (64'd1 << w) - 1;
         // junk above the register width must be dropped
         write_csr(csr_index_type'(i), val[i] | ({$urandom, $urandom} & ~mask));
      end
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   task automatic random_sample();
      int thr, span, rate_span, pick, i, t;
      int e [6];
      logic armed;
      thr = int'(board.run_threshold);
      pick = $urandom_range(99);
      span = 1 << $urandom_range(12, 4);
      rate_span = 1 << $urandom_range(10, 1);
      armed = 1'b1;
      if (pick < 55) begin
         // normal flight: modest angles and rates, throttle above threshold unless clipped at 65535
         for (i = 0; i < 3; i++) e[i] = spread(span);
         for (i = 3; i < 6; i++) e[i] = spread(rate_span);
         t = thr + 1 + $urandom_range(4000);
         armed = ($urandom_range(19) != 0);
      end else if (pick < 70) begin
         for (i = 0; i < 6; i++) e[i] = spread(span);
         t = thr - 2 + $urandom_range(4);
         armed = 1'($urandom);
      end else if (pick < 88) begin
         for (i = 0; i < 6; i++) e[i] = $urandom;
         t = $urandom_range(65535);
         armed = 1'($urandom);
      end else begin
         for (i = 0; i < 6; i++) e[i] = corner_value();
         case ($urandom_range(4))
            0: t = 0;
            1: t = 65535;
            2: t = thr;
            3: t = thr + 1;
            default: t = THROTTLE_OFFSET;
         endcase
         armed = 1'($urandom);
      end
      if (t > 65535) t = 65535;
      if (t < 0) t = 0;
      send_sample(pack_sample(e[0], e[1], e[2], e[3], e[4], e[5], t), armed);
   endtask

   initial begin
      int i, p, n;
      plan = '{
         '{SET_DEFAULT,  0,  0,  200},
         '{SET_MODERATE, 88, 0,  200},
         '{SET_MODERATE, 0,  88, 200},
         '{SET_MAX,      23, 23, 200},
         '{SET_ZERO,     0,  0,  200},
         '{SET_WILD,     23, 23, 200},
         '{SET_NO_RUN,   88, 0,  60},
         '{SET_MODERATE, 23, 23, 200},
         '{SET_DEFAULT,  0,  88, 200}
      };
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset gains: throttle and armed boundaries, saturation at both ends
      send_sample(pack_sample(0, 0, 0, 0, 0, 0, 0), 1'b0);
      send_sample(pack_sample(0, 0, 0, 0, 0, 0, int'(THRESH_RST)), 1'b1);
      send_sample(pack_sample(0, 0, 0, 0, 0, 0, int'(THRESH_RST) + 1), 1'b1);
      send_sample(pack_sample(0, 0, 0, 0, 0, 0, 65535), 1'b1);
      send_sample(pack_sample(0, 0, 0, 0, 0, 0, 65535), 1'b0);
      send_sample(pack_sample(32767, 32767, 32767, 32767, 32767, 32767, 65535), 1'b1);
      send_sample(pack_sample(-32768, -32768, -32768, -32768, -32768, -32768, 1500), 1'b1);
      send_sample(pack_sample(32767, 32767, 32767, -32768, -32768, -32768, 30000), 1'b1);
      send_sample(pack_sample(0, 0, 0, 0, 0, 0, 2000), 1'b1);
      send_sample(pack_sample(-32768, 32767, 0, 32767, -32768, -1, 30000), 1'b1);
      drain();

      // integral winds into the clamp from both sides
      apply_settings(SET_CLAMP);
      for (i = 0; i < 3; i++)
         send_sample(pack_sample(5000, 5000, 5000, 40, 40, 40, 3000), 1'b1);
      for (i = 0; i < 3; i++)
         send_sample(pack_sample(-5000, -5000, -5000, -40, -40, -40, 3000), 1'b1);
      send_sample(pack_sample(0, 0, 0, 0, 0, 0, 3000), 1'b1);
      send_sample(pack_sample(0, 0, 0, 0, 0, 0, int'(THRESH_RST)), 1'b1);

      for (p = 0; p < NUM_PHASES; p++) begin
         drain();
         apply_settings(plan[p].gains);
         send_idle_pct  = plan[p].send_idle;
         recv_stall_pct = plan[p].recv_stall;
         for (n = 0; n < plan[p].samples; n++) begin
            if (n == plan[p].samples / 2) drain();
            random_sample();
         end
      end
      drain();
      repeat (24) @(posedge clock);

      $display("covered %0d samples over %0d gain settings, %0d motor transactions checked,",
               samples_sent, settings_loaded, board.drives_checked);
      $display("with sender gaps, receiver stalls, both and neither");
      if (board.mismatches == 0) begin
         $display("[quad_cascaded_pid_mixer_core] OK");
      end else begin
         $display("[quad_cascaded_pid_mixer_core] ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/qcpm_pkg.sv
rtl/qcpm_csr.sv
rtl/qcpm_ctrl.sv
rtl/qcpm_dp.sv
rtl/quad_cascaded_pid_mixer_core.sv
tb/quad_cascaded_pid_mixer_core_test.sv
